FILE: rtl/core/bwrf_alu_pkg.sv
// Package with the command, function and status codes of the bitwise register file unit.
`timescale 1ns / 1ps

package bwrf_alu_pkg;

  localparam int NumVarsDefault   = 26;
  localparam int DataWidthDefault = 32;

  localparam int CmdW    = 2;
  localparam int IdxW    = 5;
  localparam int FuncW   = 4;
  localparam int WordW   = 32;
  localparam int StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_NOT    = 2'd2,
    CMD_BINARY = 2'd3
  } cmd_t;

  localparam logic [FuncW-1:0] FN_OR      = 4'd0;
  localparam logic [FuncW-1:0] FN_AND_NOT = 4'd1;
  localparam logic [FuncW-1:0] FN_AND     = 4'd2;
  localparam logic [FuncW-1:0] FN_IMPL    = 4'd3;
  localparam logic [FuncW-1:0] FN_CONV    = 4'd4;
  localparam logic [FuncW-1:0] FN_XOR     = 4'd5;
  localparam logic [FuncW-1:0] FN_XNOR    = 4'd6;
  localparam logic [FuncW-1:0] FN_NAND    = 4'd7;
  localparam logic [FuncW-1:0] FN_NOR     = 4'd8;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_UNINIT  = 2'd1;
  localparam logic [StatusW-1:0] ST_BADFUNC = 2'd2;

endpackage

FILE: rtl/core/bitwise_register_file_alu_core.sv
// Top level: register file of signed variables with a bitwise logic unit.
// An accepted word goes through the input register, then the result register.
// One word is taken per cycle while no stall holds; the two registers set the pace.
// The input side stalls only while a result waits and the input register is full.
// Reset clears all valid bits and the pipeline; variable contents stay undefined.
`timescale 1ns / 1ps

module bitwise_register_file_alu_core
  import bwrf_alu_pkg::*;
#(
  parameter int NUM_VARS   = NumVarsDefault,
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CmdW-1:0]           cmd,
  input  logic [IdxW-1:0]           dest,
  input  logic [IdxW-1:0]           src_a,
  input  logic [IdxW-1:0]           src_b,
  input  logic [FuncW-1:0]          func,
  input  logic signed [WordW-1:0]   load_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [StatusW-1:0]        status,
  output logic signed [WordW-1:0]   read_value
);

  localparam int AddrW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int ExtW  = ((AddrW > IdxW) ? AddrW : IdxW) + 1;
  localparam int LdW   = (DATA_WIDTH > WordW) ? DATA_WIDTH : WordW;

  logic [DATA_WIDTH-1:0] mem [NUM_VARS];
  logic [NUM_VARS-1:0]   var_valid;

  logic                  s1_valid;
  cmd_t                  s1_cmd;
  logic [AddrW-1:0]      s1_dest;
  logic                  s1_dest_ok;
  logic [FuncW-1:0]      s1_func;
  logic [DATA_WIDTH-1:0] s1_load;
  logic [DATA_WIDTH-1:0] s1_rd_a;
  logic [DATA_WIDTH-1:0] s1_rd_b;
  logic                  s1_byp_a;
  logic                  s1_byp_b;
  logic [DATA_WIDTH-1:0] s1_byp_data;
  logic                  s1_ok_a;
  logic                  s1_ok_b;

  logic                  s1_adv;
  logic                  accept;
  logic [ExtW-1:0]       dest_ext;
  logic [ExtW-1:0]       a_ext;
  logic [ExtW-1:0]       b_ext;
  logic [AddrW-1:0]      addr_a;
  logic [AddrW-1:0]      addr_b;
  logic [AddrW-1:0]      addr_d;
  logic                  in_range_a;
  logic                  in_range_b;
  logic                  in_range_d;
  logic                  hit_a;
  logic                  hit_b;
  logic [LdW-1:0]        load_ext;

  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  logic [DATA_WIDTH-1:0] fn_result;
  logic                  fn_known;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [StatusW-1:0]    st_next;
  logic [WordW-1:0]      rv_next;
  logic [LdW-1:0]        rd_ext;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Port A serves the variable named by a read command and the first source otherwise.
  always_comb begin
    dest_ext   = ExtW'(dest);
    a_ext      = (cmd_t'(cmd) == CMD_READ) ? ExtW'(dest) : ExtW'(src_a);
    b_ext      = ExtW'(src_b);
    addr_d     = dest_ext[AddrW-1:0];
    addr_a     = a_ext[AddrW-1:0];
    addr_b     = b_ext[AddrW-1:0];
    in_range_d = dest_ext < ExtW'(NUM_VARS);
    in_range_a = a_ext < ExtW'(NUM_VARS);
    in_range_b = b_ext < ExtW'(NUM_VARS);
    hit_a      = wr_en && (s1_dest == addr_a);
    hit_b      = wr_en && (s1_dest == addr_b);
    load_ext   = LdW'(load_value);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_dest] <= wr_data;
    end
    if (accept) begin
      s1_rd_a <= mem[addr_a];
      s1_rd_b <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      var_valid <= '0;
    end else if (wr_en) begin
      var_valid[s1_dest] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv || !s1_valid) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd_t'(cmd);
      s1_dest     <= addr_d;
      s1_dest_ok  <= in_range_d;
      s1_func     <= func;
      s1_load     <= load_ext[DATA_WIDTH-1:0];
      s1_byp_a    <= hit_a;
      s1_byp_b    <= hit_b;
      s1_byp_data <= wr_data;
      s1_ok_a     <= in_range_a && (var_valid[addr_a] || hit_a);
      s1_ok_b     <= in_range_b && (var_valid[addr_b] || hit_b);
    end
  end

  // Operands take the word written back in the cycle they were read.
  assign op_a = s1_byp_a ? s1_byp_data : s1_rd_a;
  assign op_b = s1_byp_b ? s1_byp_data : s1_rd_b;

  always_comb begin
    fn_known = 1'b1;
    unique case (s1_func)
      FN_OR:      fn_result = op_a | op_b;
      FN_AND_NOT: fn_result = op_a & ~op_b;
      FN_AND:     fn_result = op_a & op_b;
      FN_IMPL:    fn_result = ~op_a | op_b;
      FN_CONV:    fn_result = op_a | ~op_b;
      FN_XOR:     fn_result = op_a ^ op_b;
      FN_XNOR:    fn_result = ~(op_a ^ op_b);
      FN_NAND:    fn_result = ~(op_a & op_b);
      FN_NOR:     fn_result = ~(op_a | op_b);
      default: begin
        fn_result = '0;
        fn_known  = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic do_write;
    do_write = 1'b0;
    wr_data  = s1_load;
    st_next  = ST_OK;
    rv_next  = '0;
    rd_ext   = LdW'(op_a);
    unique case (s1_cmd)
      CMD_LOAD: begin
        do_write = 1'b1;
      end
      CMD_READ: begin
        if (s1_ok_a) begin
          rv_next = rd_ext[WordW-1:0];
        end else begin
          st_next = ST_UNINIT;
        end
      end
      CMD_NOT: begin
        wr_data = ~op_a;
        if (s1_ok_a) begin
          do_write = 1'b1;
        end else begin
          st_next = ST_UNINIT;
        end
      end
      CMD_BINARY: begin
        wr_data = fn_result;
        if (!s1_ok_a || !s1_ok_b) begin
          st_next = ST_UNINIT;
        end else if (fn_known) begin
          do_write = 1'b1;
        end else begin
          st_next = ST_BADFUNC;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
    wr_en = s1_valid && s1_adv && do_write && s1_dest_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      status     <= st_next;
      read_value <= signed'(rv_next);
    end
  end

endmodule

FILE: rtl/core/bwrf_alu_checker.sv
// Port checker for the bitwise register file unit, bound to the top level.
`timescale 1ns / 1ps

module bwrf_alu_checker
  import bwrf_alu_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [StatusW-1:0]      status,
  input logic signed [WordW-1:0] read_value
);

  // A result word always carries one of the three defined status codes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_UNINIT || status == ST_BADFUNC))
    else $error("result word with undefined status");

  // A failed command never returns data.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_value == '0))
    else $error("nonzero data on failed command");

  // The input side stalls only when the result side is stalled.
  assert property (@(posedge clk) disable iff (rst)
    (!out_stall) |-> (!in_stall))
    else $error("input stalled while output is free");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_value)))
    else $error("stalled result word changed");

endmodule

bind bitwise_register_file_alu_core bwrf_alu_checker u_bwrf_alu_checker (.*);
